>>> hw/rtl/fmp_pkg.sv
// Shared types and constants of the management frame parser.
package fmp_pkg;

	localparam int HDR_LEN    = 24;
	localparam int FIXED_LEN  = 12;
	localparam int ADDR_START = 4;
	localparam int ADDR_NUM   = 3;
	localparam int ADDR_BYTES = 6;

	localparam logic [7:0] TAG_SSID      = 8'd0;
	localparam logic [7:0] TAG_DS        = 8'd3;
	localparam logic [3:0] SUB_BEACON    = 4'd8;
	localparam logic [3:0] SUB_PROBE_RSP = 4'd5;

	localparam logic KIND_SUMMARY = 1'b0;
	localparam logic KIND_SSID    = 1'b1;

	// SSID banks: pending, committed, plus banks held by queued frames
	localparam int NBANK  = 4;
	localparam int BANK_W = 2;
	// holds any SSID length up to 127
	localparam int LEN_W  = 7;
	localparam int FIFO_DEPTH = 2;
	localparam int FIFO_PTR_W = 1;

	typedef struct packed {
		logic [7:0]        frame_byte;
		logic              last_byte;
		logic signed [7:0] signal_strength;
	} in_t;

	typedef struct packed {
		logic              result_kind;
		logic              frame_valid;
		logic [3:0]        frame_subtype;
		logic [47:0]       receiver_address;
		logic [47:0]       transmitter_address;
		logic [47:0]       bss_address;
		logic [7:0]        radio_channel;
		logic signed [7:0] rssi_out;
		logic [5:0]        ssid_length;
		logic [7:0]        ssid_char;
		logic              last_result;
	} out_t;

	// one finished frame, front to back
	typedef struct packed {
		logic              valid;
		logic [3:0]        subtype;
		logic [47:0]       ra;
		logic [47:0]       ta;
		logic [47:0]       ba;
		logic [7:0]        chan;
		logic signed [7:0] rssi;
		logic [LEN_W-1:0]  slen;
		logic [BANK_W-1:0] bank;
	} desc_t;

	// bank handed back by the back end
	typedef struct packed {
		logic              vld;
		logic [BANK_W-1:0] bank;
	} rel_t;

endpackage

>>> hw/rtl/fmp_ssid_ram.sv
// Banked SSID byte store: one write port, one registered read port.
module fmp_ssid_ram #(
	parameter int ADDR_W = 7
) (
	input  logic              clk,
	input  logic              we,
	input  logic [ADDR_W-1:0] waddr,
	input  logic [7:0]        wdata,
	input  logic [ADDR_W-1:0] raddr,
	output logic [7:0]        rdata
);
	logic [7:0] mem [2**ADDR_W];
	logic [7:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata_q <= mem[raddr];
	end

	assign rdata = rdata_q;
endmodule

>>> hw/rtl/fmp_desc_fifo.sv
// Short queue of frame descriptors between parser front and emitter back.
module fmp_desc_fifo (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          wr,
	input  fmp_pkg::desc_t wdata,
	output logic          full,
	input  logic          rd,
	output fmp_pkg::desc_t rdata,
	output logic          empty
);
	import fmp_pkg::*;

	desc_t                 ent_q [FIFO_DEPTH];
	logic [FIFO_PTR_W-1:0] wptr_q, rptr_q;
	logic [FIFO_PTR_W:0]   cnt_q;
	logic                  do_wr, do_rd;

	assign full  = (cnt_q == (FIFO_PTR_W+1)'(FIFO_DEPTH));
	assign empty = (cnt_q == '0);
	assign do_wr = wr & ~full;
	assign do_rd = rd & ~empty;
	assign rdata = ent_q[rptr_q];

	always_ff @(posedge clk) begin
		if (do_wr) begin
			ent_q[wptr_q] <= wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q <= '0;
			rptr_q <= '0;
			cnt_q  <= '0;
		end else begin
			if (do_wr) wptr_q <= wptr_q + 1'b1;
			if (do_rd) rptr_q <= rptr_q + 1'b1;
			if (do_wr && !do_rd) cnt_q <= cnt_q + 1'b1;
			else if (!do_wr && do_rd) cnt_q <= cnt_q - 1'b1;
		end
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		full && !do_rd |=> full && $stable(wptr_q))
		else $error("descriptor queue lost its full state");
	a_cnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= (FIFO_PTR_W+1)'(FIFO_DEPTH))
		else $error("descriptor queue count out of range");
	a_ptr_gap: assert property (@(posedge clk) disable iff (!arst_n)
		(cnt_q == '0 || cnt_q == (FIFO_PTR_W+1)'(FIFO_DEPTH)) |-> wptr_q == rptr_q)
		else $error("descriptor queue pointers disagree with count");
endmodule

>>> hw/rtl/fmp_front.sv
// Byte-wise header capture, tag walk and SSID bank management.
module fmp_front #(
	parameter int SSID_MAX_LEN = 32,
	parameter int OFFSET_BITS  = 12,
	parameter int POS_W        = 5
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         push,
	output logic                         full,
	input  fmp_pkg::in_t                 byte_data,
	output logic                         desc_wr,
	output fmp_pkg::desc_t               desc,
	input  logic                         desc_full,
	input  fmp_pkg::rel_t                rel,
	output logic                         ram_we,
	output logic [fmp_pkg::BANK_W+POS_W-1:0] ram_waddr,
	output logic [7:0]                   ram_wdata
);
	import fmp_pkg::*;

	typedef enum logic [2:0] {
		PH_ID   = 3'b001,
		PH_LEN  = 3'b010,
		PH_BODY = 3'b100
	} phase_t;

	logic [OFFSET_BITS-1:0] off_q;
	logic [7:0]             fcb_q, fcb_nx;
	logic [47:0]            addr_q [ADDR_NUM];
	logic [47:0]            addr_nx [ADDR_NUM];
	phase_t                 phase_q, phase_nx;
	logic [7:0]             tag_id_q, tag_id_nx;
	logic [7:0]             tag_rem_q, tag_rem_nx;
	logic [7:0]             tag_pos_q, tag_pos_nx;
	logic [7:0]             pend_chan_q, pend_chan_nx;
	logic [7:0]             comm_chan_q, comm_chan_nx;
	logic [LEN_W-1:0]       pend_len_q, pend_len_nx;
	logic [LEN_W-1:0]       comm_len_q, comm_len_nx;
	logic [BANK_W-1:0]      pend_bank_q, pend_bank_nx;
	logic [BANK_W-1:0]      comm_bank_q, comm_bank_nx;
	logic [NBANK-1:0]       busy_q, busy_nx;
	logic [NBANK-1:0]       free_vec;
	logic [BANK_W-1:0]      free_bank;
	logic                   have_free;
	logic                   acc, frame_end;
	logic                   mgmt, walk, valid, commit;
	logic [3:0]             sub;
	logic [OFFSET_BITS-1:0] tstart;
	logic [7:0]             b;
	logic [LEN_W-1:0]       slen;

	assign b = byte_data.frame_byte;

	// banks neither pending, committed nor held downstream
	always_comb begin
		free_vec = ~busy_q;
		free_vec[pend_bank_q] = 1'b0;
		free_vec[comm_bank_q] = 1'b0;
		free_bank = '0;
		for (int i = NBANK - 1; i >= 0; i--) begin
			if (free_vec[i]) free_bank = BANK_W'(i);
		end
	end
	assign have_free = |free_vec;

	assign full      = desc_full | ~have_free;
	assign acc       = push & ~full;
	assign frame_end = acc & byte_data.last_byte;

	always_comb begin
		fcb_nx = (off_q == '0) ? b : fcb_q;
		for (int a = 0; a < ADDR_NUM; a++) begin
			addr_nx[a] = addr_q[a];
			for (int j = 0; j < ADDR_BYTES; j++) begin
				if (off_q == OFFSET_BITS'(ADDR_START + a * ADDR_BYTES + j)) begin
					addr_nx[a][j*8 +: 8] = addr_q[a][j*8 +: 8] | b;
				end
			end
		end
		mgmt   = (fcb_nx[3:2] == 2'b00);
		sub    = fcb_nx[7:4];
		tstart = (sub == SUB_BEACON || sub == SUB_PROBE_RSP) ?
			OFFSET_BITS'(HDR_LEN + FIXED_LEN) : OFFSET_BITS'(HDR_LEN);
		walk   = mgmt && (off_q >= tstart);
	end

	// tag walker
	always_comb begin
		phase_nx     = phase_q;
		tag_id_nx    = tag_id_q;
		tag_rem_nx   = tag_rem_q;
		tag_pos_nx   = tag_pos_q;
		pend_chan_nx = pend_chan_q;
		comm_chan_nx = comm_chan_q;
		pend_len_nx  = pend_len_q;
		comm_len_nx  = comm_len_q;
		pend_bank_nx = pend_bank_q;
		comm_bank_nx = comm_bank_q;
		commit       = 1'b0;
		ram_we       = 1'b0;
		if (walk) begin
			unique case (phase_q)
				PH_LEN: begin
					tag_rem_nx  = b;
					tag_pos_nx  = '0;
					pend_len_nx = (b > 8'(SSID_MAX_LEN)) ? LEN_W'(SSID_MAX_LEN) : LEN_W'(b);
					if (b == 8'd0) begin
						commit   = 1'b1;
						phase_nx = PH_ID;
					end else begin
						phase_nx = PH_BODY;
					end
				end
				PH_BODY: begin
					ram_we = acc && (tag_id_q == TAG_SSID) &&
						(tag_pos_q < 8'(SSID_MAX_LEN));
					if (tag_id_q == TAG_DS && tag_pos_q == 8'd0) pend_chan_nx = b;
					tag_pos_nx = tag_pos_q + 8'd1;
					tag_rem_nx = tag_rem_q - 8'd1;
					if (tag_rem_q == 8'd1) begin
						commit   = 1'b1;
						phase_nx = PH_ID;
					end
				end
				default: begin
					// unused phase codes act as expect-id
					tag_id_nx = b;
					phase_nx  = PH_LEN;
				end
			endcase
		end
		if (commit) begin
			if (tag_id_q == TAG_SSID) begin
				// swap instead of copy: pending bank becomes the committed one
				comm_len_nx  = pend_len_nx;
				comm_bank_nx = pend_bank_q;
				pend_bank_nx = comm_bank_q;
			end else if (tag_id_q == TAG_DS && tag_pos_nx != 8'd0) begin
				comm_chan_nx = pend_chan_nx;
			end
		end
	end

	assign ram_waddr = {pend_bank_q, tag_pos_q[POS_W-1:0]};
	assign ram_wdata = b;

	assign valid = mgmt && (off_q >= OFFSET_BITS'(HDR_LEN - 1));
	assign slen  = valid ? comm_len_nx : '0;

	assign desc_wr    = frame_end;
	assign desc.valid = valid;
	assign desc.subtype = valid ? sub : 4'd0;
	assign desc.ra    = valid ? addr_nx[0] : 48'd0;
	assign desc.ta    = valid ? addr_nx[1] : 48'd0;
	assign desc.ba    = valid ? addr_nx[2] : 48'd0;
	assign desc.chan  = valid ? comm_chan_nx : 8'd0;
	assign desc.rssi  = byte_data.signal_strength;
	assign desc.slen  = slen;
	assign desc.bank  = comm_bank_nx;

	always_comb begin
		busy_nx = busy_q;
		if (rel.vld) busy_nx[rel.bank] = 1'b0;
		if (frame_end && slen != '0) busy_nx[comm_bank_nx] = 1'b1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			off_q       <= '0;
			fcb_q       <= '0;
			for (int a = 0; a < ADDR_NUM; a++) addr_q[a] <= '0;
			phase_q     <= PH_ID;
			tag_id_q    <= '0;
			tag_rem_q   <= '0;
			tag_pos_q   <= '0;
			pend_chan_q <= '0;
			comm_chan_q <= '0;
			pend_len_q  <= '0;
			comm_len_q  <= '0;
			pend_bank_q <= BANK_W'(0);
			comm_bank_q <= BANK_W'(1);
			busy_q      <= '0;
		end else begin
			busy_q <= busy_nx;
			if (frame_end) begin
				off_q       <= '0;
				fcb_q       <= '0;
				for (int a = 0; a < ADDR_NUM; a++) addr_q[a] <= '0;
				phase_q     <= PH_ID;
				tag_id_q    <= '0;
				tag_rem_q   <= '0;
				tag_pos_q   <= '0;
				pend_chan_q <= '0;
				comm_chan_q <= '0;
				pend_len_q  <= '0;
				comm_len_q  <= '0;
				pend_bank_q <= pend_bank_nx;
				// a committed bank with SSID bytes goes downstream; take a fresh one
				comm_bank_q <= (slen != '0) ? free_bank : comm_bank_nx;
			end else if (acc) begin
				if (off_q != '1) off_q <= off_q + 1'b1;
				fcb_q       <= fcb_nx;
				for (int a = 0; a < ADDR_NUM; a++) addr_q[a] <= addr_nx[a];
				phase_q     <= phase_nx;
				tag_id_q    <= tag_id_nx;
				tag_rem_q   <= tag_rem_nx;
				tag_pos_q   <= tag_pos_nx;
				pend_chan_q <= pend_chan_nx;
				comm_chan_q <= comm_chan_nx;
				pend_len_q  <= pend_len_nx;
				comm_len_q  <= comm_len_nx;
				pend_bank_q <= pend_bank_nx;
				comm_bank_q <= comm_bank_nx;
			end
		end
	end

	a_banks_differ: assert property (@(posedge clk) disable iff (!arst_n)
		pend_bank_q != comm_bank_q)
		else $error("pending and committed SSID banks collide");
	a_owned_not_busy: assert property (@(posedge clk) disable iff (!arst_n)
		!busy_q[pend_bank_q] && !busy_q[comm_bank_q])
		else $error("front writes a bank held downstream");
	a_frame_restart: assert property (@(posedge clk) disable iff (!arst_n)
		frame_end |=> off_q == '0 && comm_len_q == '0 && phase_q == PH_ID)
		else $error("per-frame state not cleared after last byte");
endmodule

>>> hw/rtl/fmp_back.sv
// Result emitter: summary, then SSID bytes read from the bank store.
module fmp_back #(
	parameter int POS_W = 5
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  fmp_pkg::desc_t               desc,
	input  logic                         desc_empty,
	output logic                         desc_rd,
	output logic [fmp_pkg::BANK_W+POS_W-1:0] ram_raddr,
	input  logic [7:0]                   ram_rdata,
	output fmp_pkg::rel_t                rel,
	output logic                         empty,
	input  logic                         pop,
	output fmp_pkg::out_t                result
);
	import fmp_pkg::*;

	typedef enum logic [2:0] {
		ST_SUM = 3'b001,
		ST_RD  = 3'b010,
		ST_CHR = 3'b100
	} st_t;

	st_t               st_q;
	logic [BANK_W-1:0] bank_q;
	logic [LEN_W-1:0]  len_q;
	logic [POS_W-1:0]  idx_q;
	out_t              out_q;
	logic              out_vld_q;
	logic              slot_free, load_sum, load_chr, chr_last;

	assign slot_free = ~out_vld_q | pop;
	assign load_sum  = (st_q == ST_SUM) && !desc_empty && slot_free;
	assign load_chr  = (st_q == ST_CHR) && slot_free;
	assign chr_last  = (LEN_W'(idx_q) + 1'b1) == len_q;

	assign desc_rd   = load_sum;
	assign ram_raddr = {bank_q, idx_q};
	assign rel.vld   = load_chr && chr_last;
	assign rel.bank  = bank_q;
	assign empty     = ~out_vld_q;
	assign result    = out_q;

	always_ff @(posedge clk) begin
		if (load_sum) begin
			out_q.result_kind         <= KIND_SUMMARY;
			out_q.frame_valid         <= desc.valid;
			out_q.frame_subtype       <= desc.subtype;
			out_q.receiver_address    <= desc.ra;
			out_q.transmitter_address <= desc.ta;
			out_q.bss_address         <= desc.ba;
			out_q.radio_channel       <= desc.chan;
			out_q.rssi_out            <= desc.rssi;
			out_q.ssid_length         <= desc.slen[5:0];
			out_q.ssid_char           <= 8'd0;
			out_q.last_result         <= (desc.slen == '0);
		end else if (load_chr) begin
			out_q.result_kind         <= KIND_SSID;
			out_q.frame_valid         <= 1'b0;
			out_q.frame_subtype       <= 4'd0;
			out_q.receiver_address    <= 48'd0;
			out_q.transmitter_address <= 48'd0;
			out_q.bss_address         <= 48'd0;
			out_q.radio_channel       <= 8'd0;
			out_q.rssi_out            <= 8'sd0;
			out_q.ssid_length         <= 6'd0;
			out_q.ssid_char           <= ram_rdata;
			out_q.last_result         <= chr_last;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q      <= ST_SUM;
			bank_q    <= '0;
			len_q     <= '0;
			idx_q     <= '0;
			out_vld_q <= 1'b0;
		end else begin
			if (load_sum || load_chr) out_vld_q <= 1'b1;
			else if (pop) out_vld_q <= 1'b0;
			unique case (st_q)
				ST_SUM: begin
					if (load_sum) begin
						bank_q <= desc.bank;
						len_q  <= desc.slen;
						idx_q  <= '0;
						if (desc.slen != '0) st_q <= ST_RD;
					end
				end
				ST_RD: begin
					st_q <= ST_CHR;
				end
				ST_CHR: begin
					if (load_chr) begin
						if (chr_last) begin
							st_q <= ST_SUM;
						end else begin
							idx_q <= idx_q + 1'b1;
							st_q  <= ST_RD;
						end
					end
				end
				default: st_q <= ST_SUM;
			endcase
		end
	end

	a_rd_then_chr: assert property (@(posedge clk) disable iff (!arst_n)
		st_q == ST_RD |=> st_q == ST_CHR && $stable(idx_q))
		else $error("SSID read not followed by its data cycle");
	a_release_once: assert property (@(posedge clk) disable iff (!arst_n)
		rel.vld |=> st_q == ST_SUM && !rel.vld)
		else $error("SSID bank released twice");
	a_idx_bound: assert property (@(posedge clk) disable iff (!arst_n)
		st_q != ST_SUM |-> LEN_W'(idx_q) < len_q)
		else $error("SSID index beyond its length");
endmodule

>>> hw/rtl/wifi_mgmt_frame_parser_core.sv
// Top level of the 802.11 management frame parser.
//
//  channel  | handshake               | payload
//  ---------+-------------------------+------------------------------------------
//  input    | push / full             | byte_data: frame_byte, last_byte, rssi
//  result   | empty / pop             | result: summary item, then SSID items
//
//  The front takes one byte per cycle while full is low; header capture and tag
//  walking keep pace with the byte stream.
//  At the last byte a descriptor enters a two-entry queue; the back emits the
//  summary, then each SSID byte as a store read followed by its output.
//  full rises when the descriptor queue is full or no SSID bank is free; a
//  frame holding a bank keeps it until its final SSID byte is emitted.
//  Reset (arst_n low) clears all control state; no clearing pass is needed.
module wifi_mgmt_frame_parser_core #(
	parameter int SSID_MAX_LEN = 32,
	parameter int OFFSET_BITS  = 12
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	output logic           full,
	input  fmp_pkg::in_t   byte_data,
	output logic           empty,
	input  logic           pop,
	output fmp_pkg::out_t  result
);
	import fmp_pkg::*;

	// address bits of a byte position within an SSID bank in the store
	localparam int POS_W  = (SSID_MAX_LEN > 1) ? $clog2(SSID_MAX_LEN) : 1;
	localparam int ADDR_W = BANK_W + POS_W;

	desc_t             fe_desc, be_desc;
	logic              fe_desc_wr, q_full, q_empty, be_desc_rd;
	rel_t              be_rel;
	logic              ram_we;
	logic [ADDR_W-1:0] ram_waddr, ram_raddr;
	logic [7:0]        ram_wdata, ram_rdata;

	fmp_front #(
		.SSID_MAX_LEN(SSID_MAX_LEN),
		.OFFSET_BITS (OFFSET_BITS),
		.POS_W       (POS_W)
	) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.full     (full),
		.byte_data(byte_data),
		.desc_wr  (fe_desc_wr),
		.desc     (fe_desc),
		.desc_full(q_full),
		.rel      (be_rel),
		.ram_we   (ram_we),
		.ram_waddr(ram_waddr),
		.ram_wdata(ram_wdata)
	);

	// SSID banks: front writes the pending bank, back reads handed-off banks
	fmp_ssid_ram #(
		.ADDR_W(ADDR_W)
	) u_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	fmp_desc_fifo u_fifo (
		.clk   (clk),
		.arst_n(arst_n),
		.wr    (fe_desc_wr),
		.wdata (fe_desc),
		.full  (q_full),
		.rd    (be_desc_rd),
		.rdata (be_desc),
		.empty (q_empty)
	);

	fmp_back #(
		.POS_W(POS_W)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.desc      (be_desc),
		.desc_empty(q_empty),
		.desc_rd   (be_desc_rd),
		.ram_raddr (ram_raddr),
		.ram_rdata (ram_rdata),
		.rel       (be_rel),
		.empty     (empty),
		.pop       (pop),
		.result    (result)
	);
endmodule
